// ===== hdl/jbsd_pkg.sv =====
// ----------------------------------------------------------------------------
// JVM bytecode decoder package
// Shared record types, opcode constants and the instruction length table.
// ----------------------------------------------------------------------------
`default_nettype none

package jbsd_pkg;

	// Default width of the code position counter.
	localparam int PC_BITS_DEF = 16;
	// Number of slots in the queue between front and back.
	localparam int QDEPTH = 4;

	// Record kinds.
	localparam logic [1:0] KIND_PLAIN   = 2'd0;
	localparam logic [1:0] KIND_CASE    = 2'd1;
	localparam logic [1:0] KIND_DEFAULT = 2'd2;

	// Opcodes that need special handling.
	localparam logic [7:0] OPC_IINC           = 8'h84;
	localparam logic [7:0] OPC_TABLESWITCH    = 8'hAA;
	localparam logic [7:0] OPC_LOOKUPSWITCH   = 8'hAB;
	localparam logic [7:0] OPC_WIDE           = 8'hC4;
	localparam logic [7:0] OPC_MULTIANEWARRAY = 8'hC5;
	localparam logic [7:0] OPC_INVOKEIFACE    = 8'hB9;
	localparam logic [7:0] OPC_INVOKEDYN      = 8'hBA;

	// One output record.
	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] pc;
		logic [7:0]  opcode;
		logic [7:0]  sub;
		logic [15:0] len;
		logic [15:0] idx;
		logic [15:0] val;
		logic [31:0] tgt;
		logic        has;
		logic [31:0] key;
		logic        last;
	} rec_t;

	// Records caused by one byte: zero, one or two.
	typedef struct packed {
		logic [1:0] cnt;
		rec_t       r0;
		rec_t       r1;
	} slot_t;

	// Branches with a 16-bit offset: the conditional ones, goto and jsr.
	function automatic logic is_branch16(input logic [7:0] op);
		return (op inside {[8'h99:8'hA8]}) || op == 8'hC6 || op == 8'hC7;
	endfunction

	// goto_w and jsr_w.
	function automatic logic is_wide_branch(input logic [7:0] op);
		return op == 8'hC8 || op == 8'hC9;
	endfunction

	// Total length of a fixed-size instruction.
	function automatic logic [2:0] fixed_len(input logic [7:0] op, input logic [7:0] sub);
		logic [2:0] n;
		n = 3'd1;
		if (op inside {8'h10, 8'h12, 8'hBC, 8'hA9, [8'h15:8'h19], [8'h36:8'h3A]})
			n = 3'd2;
		else if (op inside {8'h11, 8'h13, 8'h14, OPC_IINC, [8'hB2:8'hB8], 8'hBB, 8'hBD,
				8'hC0, 8'hC1} || is_branch16(op))
			n = 3'd3;
		else if (op == OPC_INVOKEIFACE || op == OPC_INVOKEDYN || is_wide_branch(op))
			n = 3'd5;
		else if (op == OPC_MULTIANEWARRAY)
			n = 3'd4;
		else if (op == OPC_WIDE)
			n = (sub == OPC_IINC) ? 3'd6 : 3'd4;
		return n;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/jbsd_front.sv =====
// ----------------------------------------------------------------------------
// Decoder front end
// Parses the byte stream and forms the records that each byte completes.
// ----------------------------------------------------------------------------
`default_nettype none

module jbsd_front import jbsd_pkg::*; #(
	parameter int PC_BITS = PC_BITS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       accept,
	input  wire logic [7:0] code_byte,
	input  wire logic       start_req,
	output logic            push,
	output slot_t           slot
);

	typedef enum logic [3:0] {
		PH_OPCODE, PH_FIXED, PH_PAD, PH_DEFAULT, PH_LOW,
		PH_HIGH, PH_NPAIRS, PH_MATCH, PH_OFFSET
	} phase_t;

	logic [PC_BITS-1:0] pos_q, start_q, pos_d, start_d;
	logic [7:0]         op_q, op_d, wide_q, wide_d;
	phase_t             phase_q, phase_d;
	logic [15:0]        nb_q, nb_d, hidx_q, hidx_d;
	logic [31:0]        word_q, word_d, dflt_q, dflt_d, key_q, key_d;
	logic [32:0]        left_q, left_d;

	// Next-state and record formation for one accepted byte.
	always_comb begin
		logic [PC_BITS-1:0] pos;
		phase_t             ph;
		logic [31:0]        w, pc32, off16;
		logic signed [32:0] diff;
		pos      = start_req ? '0 : pos_q;
		ph       = start_req ? PH_OPCODE : phase_q;
		w        = {word_q[23:0], code_byte};
		pc32     = 32'(start_q);
		off16    = {{16{w[15]}}, w[15:0]};
		diff     = $signed({w[31], w}) - $signed({key_q[31], key_q});
		pos_d    = pos_q;
		start_d  = start_q;
		op_d     = op_q;
		wide_d   = wide_q;
		phase_d  = phase_q;
		nb_d     = nb_q;
		hidx_d   = hidx_q;
		word_d   = word_q;
		dflt_d   = dflt_q;
		key_d    = key_q;
		left_d   = left_q;
		slot     = '0;
		if (accept) begin
			pos_d = pos + 1'b1;
			phase_d = ph;
			if (ph == PH_OPCODE) begin
				start_d = pos;
				op_d    = code_byte;
				nb_d    = 16'd1;
				word_d  = '0;
				wide_d  = '0;
				hidx_d  = '0;
				if (code_byte == OPC_TABLESWITCH || code_byte == OPC_LOOKUPSWITCH) begin
					phase_d = (pos[1:0] == 2'd3) ? PH_DEFAULT : PH_PAD;
				end else if (fixed_len(code_byte, 8'd0) == 3'd1) begin
					slot.cnt = 2'd1;
					slot.r0.kind = KIND_PLAIN;
					slot.r0.pc = 16'(pos);
					slot.r0.opcode = code_byte;
					slot.r0.len = 16'd1;
					slot.r0.last = 1'b1;
				end else begin
					phase_d = PH_FIXED;
				end
			end else begin
				if (nb_q != 16'hFFFF)
					nb_d = nb_q + 16'd1;
				word_d = w;
				if (ph == PH_FIXED) begin
					if (op_q == OPC_WIDE && nb_d == 16'd2) wide_d = code_byte;
					if (op_q == OPC_WIDE && nb_d == 16'd4) hidx_d = w[15:0];
					if (op_q == OPC_IINC && nb_d == 16'd2) hidx_d = {8'd0, code_byte};
					if ((op_q == OPC_MULTIANEWARRAY || op_q == OPC_INVOKEIFACE ||
							op_q == OPC_INVOKEDYN) && nb_d == 16'd3)
						hidx_d = w[15:0];
					if (nb_d >= 16'(fixed_len(op_q, wide_d))) begin
						phase_d = PH_OPCODE;
						slot.cnt = 2'd1;
						slot.r0.kind = KIND_PLAIN;
						slot.r0.pc = 16'(start_q);
						slot.r0.opcode = op_q;
						slot.r0.len = nb_d;
						slot.r0.last = 1'b1;
						if (op_q == OPC_WIDE) begin
							slot.r0.sub = wide_d;
							slot.r0.idx = hidx_d;
							if (wide_d == OPC_IINC) slot.r0.val = w[15:0];
						end else if (op_q == OPC_MULTIANEWARRAY || op_q == OPC_IINC) begin
							slot.r0.idx = hidx_d;
							slot.r0.val = {8'd0, code_byte};
						end else if (op_q == OPC_INVOKEIFACE || op_q == OPC_INVOKEDYN) begin
							slot.r0.idx = hidx_d;
						end else if (is_branch16(op_q)) begin
							slot.r0.tgt = pc32 + off16;
							slot.r0.has = 1'b1;
						end else if (is_wide_branch(op_q)) begin
							slot.r0.tgt = pc32 + w;
							slot.r0.has = 1'b1;
						end else begin
							slot.r0.idx = w[15:0];
						end
					end
				end else if (pos[1:0] == 2'd3) begin
					// Default record template, used when the switch ends.
					slot.r1.kind = KIND_DEFAULT;
					slot.r1.pc = 16'(start_q);
					slot.r1.opcode = op_q;
					slot.r1.len = nb_d;
					slot.r1.tgt = dflt_q;
					slot.r1.has = 1'b1;
					slot.r1.last = 1'b1;
					case (ph)
						PH_PAD: phase_d = PH_DEFAULT;
						PH_DEFAULT: begin
							dflt_d = pc32 + w;
							phase_d = (op_q == OPC_TABLESWITCH) ? PH_LOW : PH_NPAIRS;
						end
						PH_LOW: begin
							key_d = w;
							phase_d = PH_HIGH;
						end
						PH_HIGH: begin
							if ($signed(w) < $signed(key_q)) begin
								left_d = '0;
								phase_d = PH_OPCODE;
								slot.cnt = 2'd1;
								slot.r0 = slot.r1;
							end else begin
								left_d = 33'(diff) + 33'd1;
								phase_d = PH_OFFSET;
							end
						end
						PH_NPAIRS: begin
							left_d = {1'b0, w};
							if (w == 32'd0) begin
								phase_d = PH_OPCODE;
								slot.cnt = 2'd1;
								slot.r0 = slot.r1;
							end else begin
								phase_d = PH_MATCH;
							end
						end
						PH_MATCH: begin
							key_d = w;
							phase_d = PH_OFFSET;
						end
						PH_OFFSET: begin
							slot.cnt = 2'd1;
							slot.r0 = '0;
							slot.r0.kind = KIND_CASE;
							slot.r0.pc = 16'(start_q);
							slot.r0.opcode = op_q;
							slot.r0.tgt = pc32 + w;
							slot.r0.has = 1'b1;
							slot.r0.key = key_q;
							if (left_q != '0) left_d = left_q - 33'd1;
							if (op_q == OPC_TABLESWITCH) begin
								key_d = key_q + 32'd1;
								phase_d = PH_OFFSET;
							end else begin
								phase_d = PH_MATCH;
							end
							if (left_d == '0) begin
								phase_d = PH_OPCODE;
								slot.cnt = 2'd2;
							end
						end
						default: phase_d = PH_OPCODE;
					endcase
				end
			end
		end
	end

	assign push = accept && (slot.cnt != 2'd0);

	// Parser state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			start_q <= '0;
			op_q    <= '0;
			wide_q  <= '0;
			phase_q <= PH_OPCODE;
			nb_q    <= '0;
			hidx_q  <= '0;
			word_q  <= '0;
			dflt_q  <= '0;
			key_q   <= '0;
			left_q  <= '0;
		end else begin
			pos_q   <= pos_d;
			start_q <= start_d;
			op_q    <= op_d;
			wide_q  <= wide_d;
			phase_q <= phase_d;
			nb_q    <= nb_d;
			hidx_q  <= hidx_d;
			word_q  <= word_d;
			dflt_q  <= dflt_d;
			key_q   <= key_d;
			left_q  <= left_d;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/jbsd_queue.sv =====
// ----------------------------------------------------------------------------
// Decoder slot queue
// Small FIFO of record slots between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module jbsd_queue import jbsd_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  slot_t      push_slot,
	input  wire logic  pop,
	output slot_t      head,
	output logic       not_empty,
	output logic       full
);

	localparam int QA = $clog2(QDEPTH);

	slot_t          mem [QDEPTH];
	logic [QA-1:0]  wr_q, rd_q;
	logic [QA:0]    cnt_q;

	assign head      = mem[rd_q];
	assign not_empty = cnt_q != '0;
	assign full      = cnt_q == (QA+1)'(QDEPTH);

	// Slot storage.
	always_ff @(posedge clk) begin
		if (push)
			mem[wr_q] <= push_slot;
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (QA+1)'(push) - (QA+1)'(pop);
		end
	end

	// The queue never overflows or underflows.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!not_empty |-> !pop) else $error("pop from empty queue");

endmodule

`default_nettype wire

// ===== hdl/jbsd_back.sv =====
// ----------------------------------------------------------------------------
// Decoder back end
// Takes slots from the queue and hands out their records one per cycle while out_stall is low.
// ----------------------------------------------------------------------------
`default_nettype none

module jbsd_back import jbsd_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  slot_t     head,
	input  wire logic not_empty,
	output logic      pop,
	input  wire logic out_stall,
	output logic      out_valid,
	output rec_t      out_rec
);

	logic out_valid_q, pend_valid_q;
	rec_t out_q, pend_q;
	logic free;

	assign free      = !out_valid_q || !out_stall;
	assign pop       = free && !pend_valid_q && not_empty;
	assign out_valid = out_valid_q;
	assign out_rec   = out_q;

	// Output register with one pending record behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else if (free) begin
			if (pend_valid_q) begin
				out_q        <= pend_q;
				out_valid_q  <= 1'b1;
				pend_valid_q <= 1'b0;
			end else if (not_empty) begin
				out_q        <= head.r0;
				out_valid_q  <= 1'b1;
				pend_q       <= head.r1;
				pend_valid_q <= head.cnt == 2'd2;
			end else begin
				out_valid_q  <= 1'b0;
			end
		end
	end

	// A pending record always sits behind a shown one.
	a_pend_behind: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> out_valid_q) else $error("pending record without output");

endmodule

`default_nettype wire

// ===== hdl/jvm_bytecode_stream_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// JVM bytecode stream decoder
// Splits a bytecode stream into instructions and emits decoded records.
// ----------------------------------------------------------------------------
//  Channel | Handshake           | Payload
//  in      | in_valid / in_stall | code_byte, start_req
//  out     | out_valid/out_stall | record_kind ... last (one record per item)
//
// One byte is accepted per cycle while in_stall is low; each byte is parsed in the cycle it arrives.
// Records pass through the queue and the output register; the back end gives one per cycle while out_stall is low.
// A switch case that ends the table gives two records from one byte.
// in_stall rises only when the four-slot queue is full. Reset is asynchronous.
// ----------------------------------------------------------------------------
`default_nettype none

module jvm_bytecode_stream_decoder_unit import jbsd_pkg::*; #(
	parameter int PC_BITS = PC_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  code_byte,
	input  wire logic        start_req,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       record_kind,
	output logic [15:0]      instr_pc,
	output logic [7:0]       opcode,
	output logic [7:0]       sub_opcode,
	output logic [15:0]      length,
	output logic [15:0]      index_operand,
	output logic [15:0]      value_operand,
	output logic [31:0]      branch_target,
	output logic             has_target,
	output logic signed [31:0] case_key,
	output logic             last
);

	logic  accept, push, pop, not_empty, full;
	slot_t slot, head;
	rec_t  rec;

	assign in_stall = full;
	assign accept   = in_valid && !full;

	jbsd_front #(.PC_BITS(PC_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .accept(accept), .code_byte(code_byte),
		.start_req(start_req), .push(push), .slot(slot)
	);

	jbsd_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_slot(slot), .pop(pop),
		.head(head), .not_empty(not_empty), .full(full)
	);

	jbsd_back u_back (
		.clk(clk), .arst_n(arst_n), .head(head), .not_empty(not_empty), .pop(pop),
		.out_stall(out_stall), .out_valid(out_valid), .out_rec(rec)
	);

	// Record fields to ports.
	assign record_kind   = rec.kind;
	assign instr_pc      = rec.pc;
	assign opcode        = rec.opcode;
	assign sub_opcode    = rec.sub;
	assign length        = rec.len;
	assign index_operand = rec.idx;
	assign value_operand = rec.val;
	assign branch_target = rec.tgt;
	assign has_target    = rec.has;
	assign case_key      = $signed(rec.key);
	assign last          = rec.last;

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// Bytecode decoder testbench
// Feeds the decoder with directed and random bytecode streams: fixed-length
// instructions, wide forms, table and lookup switches and cut-off code.
// A predictor models the parser per byte. Records are compared in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
	import jbsd_pkg::*;

	// Parser phases of the predictor.
	typedef enum logic [3:0] {
		PH_OPCODE, PH_FIXED, PH_PAD, PH_DEFAULT, PH_LOW, PH_HIGH,
		PH_NPAIRS, PH_MATCH, PH_OFFSET
	} phase_t;

	// One pending input item.
	typedef struct packed {
		logic [7:0] b;
		logic       st;
	} byte_t;

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall;
	logic [7:0] code_byte;
	logic start_req;
	logic [1:0] record_kind;
	logic [15:0] instr_pc, length, index_operand, value_operand;
	logic [7:0] opcode, sub_opcode;
	logic [31:0] branch_target;
	logic has_target, last;
	logic signed [31:0] case_key;

	jvm_bytecode_stream_decoder_unit u_dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.code_byte(code_byte), .start_req(start_req), .out_valid(out_valid),
		.out_stall(out_stall), .record_kind(record_kind), .instr_pc(instr_pc),
		.opcode(opcode), .sub_opcode(sub_opcode), .length(length),
		.index_operand(index_operand), .value_operand(value_operand),
		.branch_target(branch_target), .has_target(has_target),
		.case_key(case_key), .last(last)
	);

	byte_t pending_bytes[$];
	rec_t  expected_recs[$];
	int    errors = 0;
	int    bytes_sent = 0;
	int    recs_seen = 0;
	int    switch_recs = 0;
	bit    stim_done = 0;
	bit    calm = 0;
	bit    hold_req = 0;
	int    hold_cnt = 0;
	int    idle_cycles = 0;

	// Decoder state copy.
	logic [15:0] p_pos, p_start, p_count;
	logic [7:0]  p_op, p_wop;
	logic [31:0] p_word, p_dflt, p_key;
	logic [15:0] p_held;
	logic [32:0] p_left;
	phase_t      p_ph;

	function automatic logic br16(input logic [7:0] op);
		return (op >= 8'h99 && op <= 8'hA8) || op == 8'hC6 || op == 8'hC7;
	endfunction

	function automatic logic brw(input logic [7:0] op);
		return op == 8'hC8 || op == 8'hC9;
	endfunction

	function automatic int instr_len(input logic [7:0] op, input logic [7:0] sub);
		if (op == 8'h10 || op == 8'h12 || op == 8'hBC || op == 8'hA9) return 2;
		if ((op >= 8'h15 && op <= 8'h19) || (op >= 8'h36 && op <= 8'h3A)) return 2;
		if (op == 8'h11 || op == 8'h13 || op == 8'h14 || op == OPC_IINC) return 3;
		if (br16(op)) return 3;
		if ((op >= 8'hB2 && op <= 8'hB8) || op == 8'hBB || op == 8'hBD) return 3;
		if (op == 8'hC0 || op == 8'hC1) return 3;
		if (op == OPC_INVOKEIFACE || op == OPC_INVOKEDYN || brw(op)) return 5;
		if (op == OPC_MULTIANEWARRAY) return 4;
		if (op == OPC_WIDE) return (sub == OPC_IINC) ? 6 : 4;
		return 1;
	endfunction

	function automatic rec_t make_rec(input logic [1:0] k, input logic [7:0] sub,
			input logic [15:0] len, input logic [15:0] idx, input logic [15:0] val,
			input logic [31:0] tgt, input logic has, input logic [31:0] key,
			input logic lst);
		rec_t r;
		r.kind = k; r.pc = p_start; r.opcode = p_op; r.sub = sub; r.len = len;
		r.idx = idx; r.val = val; r.tgt = tgt; r.has = has; r.key = key;
		r.last = lst;
		return r;
	endfunction

	function automatic void push_default();
		expected_recs.push_back(make_rec(KIND_DEFAULT, 0, p_count, 0, 0, p_dflt, 1, 0, 1));
		p_ph = PH_OPCODE;
	endfunction

	// Advances the predicted decoder by one byte and queues its records.
	function automatic void decode_byte(input byte_t it);
		logic [15:0] pos;
		logic [15:0] idx, val;
		logic [31:0] tgt;
		logic has;
		logic [7:0] sub;
		logic signed [31:0] lo, hi;
		if (it.st) begin
			p_pos = 0;
			p_ph = PH_OPCODE;
		end
		pos = p_pos;
		p_pos = pos + 16'd1;
		if (p_ph == PH_OPCODE) begin
			p_start = pos; p_op = it.b; p_count = 1; p_word = 0; p_wop = 0; p_held = 0;
			if (it.b == OPC_TABLESWITCH || it.b == OPC_LOOKUPSWITCH)
				p_ph = (pos[1:0] == 2'd3) ? PH_DEFAULT : PH_PAD;
			else if (instr_len(it.b, 0) == 1)
				expected_recs.push_back(make_rec(KIND_PLAIN, 0, 1, 0, 0, 0, 0, 0, 1));
			else
				p_ph = PH_FIXED;
			return;
		end
		if (p_count != 16'hFFFF) p_count++;
		p_word = {p_word[23:0], it.b};
		if (p_ph == PH_FIXED) begin
			if (p_op == OPC_WIDE && p_count == 2) p_wop = it.b;
			if (p_op == OPC_WIDE && p_count == 4) p_held = p_word[15:0];
			if (p_op == OPC_IINC && p_count == 2) p_held = {8'd0, it.b};
			if ((p_op == OPC_MULTIANEWARRAY || p_op == OPC_INVOKEIFACE ||
					p_op == OPC_INVOKEDYN) && p_count == 3)
				p_held = p_word[15:0];
			if (p_count >= instr_len(p_op, p_wop)) begin
				idx = 0; val = 0; tgt = 0; has = 0; sub = 0;
				if (p_op == OPC_WIDE) begin
					sub = p_wop; idx = p_held;
					if (p_wop == OPC_IINC) val = p_word[15:0];
				end else if (p_op == OPC_MULTIANEWARRAY || p_op == OPC_IINC) begin
					idx = p_held; val = {8'd0, it.b};
				end else if (p_op == OPC_INVOKEIFACE || p_op == OPC_INVOKEDYN) begin
					idx = p_held;
				end else if (br16(p_op)) begin
					tgt = 32'(p_start) + {{16{p_word[15]}}, p_word[15:0]}; has = 1;
				end else if (brw(p_op)) begin
					tgt = 32'(p_start) + p_word; has = 1;
				end else begin
					idx = p_word[15:0];
				end
				expected_recs.push_back(make_rec(KIND_PLAIN, sub, p_count, idx, val, tgt,
					has, 0, 1));
				p_ph = PH_OPCODE;
			end
			return;
		end
		if (pos[1:0] != 2'd3) return;
		case (p_ph)
			PH_PAD: p_ph = PH_DEFAULT;
			PH_DEFAULT: begin
				p_dflt = 32'(p_start) + p_word;
				p_ph = (p_op == OPC_TABLESWITCH) ? PH_LOW : PH_NPAIRS;
			end
			PH_LOW: begin
				p_key = p_word; p_ph = PH_HIGH;
			end
			PH_HIGH: begin
				lo = p_key; hi = p_word;
				if (hi < lo) begin
					p_left = 0; push_default();
				end else begin
					p_left = 33'(signed'(34'(hi) - 34'(lo))) + 33'd1;
					p_ph = PH_OFFSET;
				end
			end
			PH_NPAIRS: begin
				p_left = {1'b0, p_word};
				if (p_word == 0) push_default(); else p_ph = PH_MATCH;
			end
			PH_MATCH: begin
				p_key = p_word; p_ph = PH_OFFSET;
			end
			PH_OFFSET: begin
				expected_recs.push_back(make_rec(KIND_CASE, 0, 0, 0, 0,
					32'(p_start) + p_word, 1, p_key, 0));
				if (p_left != 0) p_left--;
				if (p_op == OPC_TABLESWITCH) p_key++; else p_ph = PH_MATCH;
				if (p_left == 0) push_default();
			end
			default: p_ph = PH_OPCODE;
		endcase
	endfunction

	// Stimulus helpers: they append bytes and track the code position.
	int gen_pos = 0;

	task automatic put_b(input logic [7:0] b, input logic st = 0);
		byte_t it;
		it.b = b; it.st = st;
		if (st) gen_pos = 0;
		pending_bytes.push_back(it);
		gen_pos++;
	endtask

	task automatic put_w(input logic [31:0] w);
		for (int i = 3; i >= 0; i--) put_b(w[i*8 +: 8]);
	endtask

	task automatic put_switch(input logic table_kind, input int n,
			input logic [31:0] lo_key);
		put_b(table_kind ? OPC_TABLESWITCH : OPC_LOOKUPSWITCH);
		while (gen_pos % 4 != 0) put_b(8'($urandom));
		put_w($urandom);
		if (table_kind) begin
			put_w(lo_key);
			put_w(n == 0 ? lo_key - 1 - $urandom_range(0, 3) : lo_key + n - 1);
			for (int i = 0; i < n; i++) put_w($urandom);
		end else begin
			put_w(n);
			for (int i = 0; i < n; i++) begin
				put_w($urandom); put_w($urandom);
			end
		end
	endtask

	task automatic put_instr();
		logic [7:0] op;
		int k;
		k = $urandom_range(0, 99);
		if (k < 5) begin
			put_switch(1'($urandom_range(0, 1)), $urandom_range(0, 3), $urandom);
		end else if (k < 12) begin
			put_b(OPC_WIDE);
			op = ($urandom_range(0, 1)) ? OPC_IINC : 8'($urandom);
			put_b(op);
			repeat (op == OPC_IINC ? 4 : 2) put_b(8'($urandom));
		end else begin
			op = 8'($urandom);
			if (op == OPC_TABLESWITCH || op == OPC_LOOKUPSWITCH || op == OPC_WIDE) op = 8'h00;
			put_b(op);
			repeat (instr_len(op, 0) - 1) put_b(8'($urandom));
		end
	endtask

	// Clock and reset.
	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
	end

	// Stimulus: directed part first, then random streams.
	initial begin
		put_b(8'h00, 1); put_b(8'hFF); put_b(8'hCB);
		put_b(8'h10); put_b(8'h80);
		put_b(8'h11); put_b(8'hFF); put_b(8'hFF);
		put_b(OPC_IINC); put_b(8'hFF); put_b(8'h80);
		put_b(8'hA7); put_b(8'h80); put_b(8'h00);
		put_b(8'hC8); put_w(32'h7FFF_FFFF);
		put_b(OPC_INVOKEIFACE); put_b(8'h12); put_b(8'h34); put_b(8'h01); put_b(8'h00);
		put_b(OPC_MULTIANEWARRAY); put_b(8'hAB); put_b(8'hCD); put_b(8'hFF);
		put_b(OPC_WIDE); put_b(OPC_IINC); put_w(32'hFFFF_8000);
		put_b(OPC_WIDE); put_b(8'h15); put_b(8'hFF); put_b(8'hFF);
		// Table keys that run up to the largest signed key and step past it.
		put_switch(1, 2, 32'h7FFF_FFFE);
		// Empty table with the high bound near the most negative key.
		put_switch(1, 0, 32'h8000_0004);
		put_switch(0, 0, 0);
		put_switch(0, 2, 0);
		// Cut-off instruction, then a switch at an aligned tail position.
		put_b(8'hC9, 1); put_b(8'h01);
		put_b(8'h00, 1); put_b(8'h00); put_b(8'h00); put_switch(1, 1, 32'hFFFF_FFFF);
		// Random streams, mostly well formed, sometimes cut off.
		while (pending_bytes.size() < 1450) begin
			if ($urandom_range(0, 19) == 0) put_b(8'($urandom), 1'b1);
			else if ($urandom_range(0, 49) == 0) put_b(8'($urandom));
			else put_instr();
		end
		stim_done = 1;
	end

	// Driver: offers the oldest pending item, idling now and then.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0; code_byte <= 0; start_req <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				decode_byte(pending_bytes.pop_front());
				bytes_sent++;
			end
			if ((!in_valid || !in_stall) ) begin
				if (pending_bytes.size() > 0 && (calm || $urandom_range(0, 99) >= 8)) begin
					in_valid <= 1;
					code_byte <= pending_bytes[0].b;
					start_req <= pending_bytes[0].st;
				end else begin
					in_valid <= 0;
				end
			end
		end
	end

	// Quiet stretch with no idling, and one long receiver hold-off.
	always @(posedge clk) begin
		calm <= (bytes_sent >= 300 && bytes_sent < 700);
		if (bytes_sent == 900 && hold_cnt == 0) hold_req <= 1;
		if (hold_req) begin
			hold_cnt <= hold_cnt + 1;
			if (hold_cnt >= 60) hold_req <= 0;
		end
	end

	// Monitor: compares each accepted record with the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		rec_t got, exp_r;
		if (!arst_n) begin
			out_stall <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				got = {record_kind, instr_pc, opcode, sub_opcode, length, index_operand,
					value_operand, branch_target, has_target, case_key, last};
				recs_seen++;
				if (got.kind != KIND_PLAIN) switch_recs++;
				if (expected_recs.size() == 0) begin
					$display("%0t: unexpected record %h", $time, got);
					errors++;
				end else begin
					exp_r = expected_recs.pop_front();
					if (got != exp_r) begin
						$display("%0t: record mismatch expected %h actual %h", $time,
							exp_r, got);
						errors++;
					end
				end
			end
			out_stall <= hold_req || (!calm && $urandom_range(0, 99) < 8);
		end
	end

	// Watchdog on cycles without any accepted item.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 2000) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// End of run.
	initial begin
		wait (stim_done);
		wait (pending_bytes.size() == 0 && !in_valid);
		wait (expected_recs.size() == 0);
		repeat (20) @(posedge clk);
		$display("Sent %0d bytecode bytes, checked %0d records (%0d from switches).",
			bytes_sent, recs_seen, switch_recs);
		if (errors == 0 && expected_recs.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

`default_nettype wire
